// File: design/bmp_pixels_to_framebuffer_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef BMP_PIXELS_TO_FRAMEBUFFER_DEFINES_SVH
`define BMP_PIXELS_TO_FRAMEBUFFER_DEFINES_SVH

// Clocked on clk_i, held off while rst_ni is low.
`define BPFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define BPFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/bpfb_pkg.sv
package bpfb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 800;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int unsigned CFG_W       = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned COORD_W     = 14;  // signed screen coordinate
  localparam int unsigned IDX_W       = 19;
  localparam int unsigned PROD_W      = 24;  // row * SCREEN_WIDTH + column, unmasked
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned OUT_TDATA_W = 56;  // IDX_W + COLOR_W rounded up to bytes

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_HAS_ALPHA    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] origin_x;
    logic signed [CFG_W-1:0] origin_y;
    logic [CFG_W-1:0]        image_width;
    logic [CFG_W-1:0]        image_height;
    logic                    has_alpha;
  } cfg_t;

  // One finished pixel with its screen position, before clipping.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } pix_t;

endpackage

// File: design/bpfb_cfg.sv
module bpfb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [bpfb_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  logic [bpfb_pkg::CFG_W-1:0]    wr_data_i,
  output bpfb_pkg::cfg_t                cfg_o
);
  import bpfb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_ORIGIN_X:     cfg_d.origin_x     = $signed(wr_data_i);
        REG_ORIGIN_Y:     cfg_d.origin_y     = $signed(wr_data_i);
        REG_IMAGE_WIDTH:  cfg_d.image_width  = wr_data_i;
        REG_IMAGE_HEIGHT: cfg_d.image_height = wr_data_i;
        REG_HAS_ALPHA:    cfg_d.has_alpha    = wr_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.image_width  <= WIDTH_RST;
      cfg_q.image_height <= HEIGHT_RST;
      cfg_q.has_alpha    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/bpfb_unpack.sv
`include "bmp_pixels_to_framebuffer_defines.svh"

module bpfb_unpack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bpfb_pkg::cfg_t cfg_i,
  input  logic           byte_valid_i,
  output logic           byte_ready_o,
  input  logic [7:0]     byte_i,
  output logic           pix_valid_o,
  input  logic           pix_ready_i,
  output bpfb_pkg::pix_t pix_o
);
  import bpfb_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic [23:0]      rgb_q, rgb_d;
  logic [CFG_W-1:0] col_q, col_d;
  logic [CFG_W-1:0] row_q, row_d;
  logic [1:0]       pad_q, pad_d;
  logic             done_q, done_d;
  logic             pv_q;
  pix_t             pix_q, pix_d;

  logic             fire;
  logic             pix_now;
  logic [7:0]       alpha;
  logic [CFG_W:0]   col_inc, row_inc;
  logic             row_end, last;

  assign byte_ready_o = !pv_q || pix_ready_i;
  assign fire         = byte_valid_i && byte_ready_o;

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign row_end = col_inc >= {1'b0, cfg_i.image_width};
  assign last    = row_end && (row_inc >= {1'b0, cfg_i.image_height});

  always_comb begin
    phase_d = phase_q;
    rgb_d   = rgb_q;
    col_d   = col_q;
    row_d   = row_q;
    pad_d   = pad_q;
    done_d  = done_q;
    pix_now = 1'b0;
    alpha   = 8'd0;
    if (fire && !done_q) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else begin
        case (phase_q)
          2'd0: begin
            rgb_d[7:0] = byte_i;
            phase_d    = 2'd1;
          end
          2'd1: begin
            rgb_d[15:8] = byte_i;
            phase_d     = 2'd2;
          end
          2'd2: begin
            rgb_d[23:16] = byte_i;
            if (cfg_i.has_alpha) begin
              phase_d = 2'd3;
            end else begin
              pix_now = 1'b1;
            end
          end
          default: begin
            alpha   = byte_i;
            pix_now = 1'b1;
          end
        endcase
        if (pix_now) begin
          phase_d = 2'd0;
          if (row_end) begin
            col_d = '0;
            row_d = row_inc[CFG_W-1:0];
            if (last) begin
              done_d = 1'b1;
            end else if (!cfg_i.has_alpha) begin
              // (4 - 3w mod 4) mod 4 reduces to w mod 4
              pad_d = cfg_i.image_width[1:0];
            end
          end else begin
            col_d = col_inc[CFG_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    pix_d.x = $signed({{(COORD_W-CFG_W){cfg_i.origin_x[CFG_W-1]}}, cfg_i.origin_x})
            + $signed({{(COORD_W-CFG_W){1'b0}}, col_q});
    pix_d.y = $signed({{(COORD_W-CFG_W){cfg_i.origin_y[CFG_W-1]}}, cfg_i.origin_y})
            + $signed({{(COORD_W-CFG_W){1'b0}}, cfg_i.image_height})
            - $signed({{(COORD_W-CFG_W){1'b0}}, row_q})
            - $signed(COORD_W'(1));
    pix_d.color = {alpha, rgb_d};
    pix_d.last  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      rgb_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pad_q   <= '0;
      done_q  <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rgb_q   <= rgb_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pad_q   <= pad_d;
      done_q  <= done_d;
      if (byte_ready_o) begin
        pv_q <= pix_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_ready_o && pix_now) begin
      pix_q <= pix_d;
    end
  end

  assign pix_valid_o = pv_q;
  assign pix_o       = pix_q;

  `BPFB_ASSERT(a_pad_at_pixel_start, pad_q != 2'd0 |-> phase_q == 2'd0, "padding mid-pixel")
  `BPFB_ASSERT(a_done_is_clean, done_q |-> (phase_q == 2'd0 && pad_q == 2'd0), "dirty end state")
  `BPFB_ASSERT(a_stall_holds, pv_q && !pix_ready_i |=> pv_q && $stable(pix_q), "pixel lost")
  `BPFB_ASSERT(a_done_sticks, done_q |=> done_q, "end of image cleared")

endmodule

// File: design/bpfb_place.sv
`include "bmp_pixels_to_framebuffer_defines.svh"

module bpfb_place (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  bpfb_pkg::pix_t              pix_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpfb_pkg::IDX_W-1:0]  index_o,
  output logic [bpfb_pkg::COLOR_W-1:0] color_o,
  output logic                        last_o
);
  import bpfb_pkg::*;

  localparam int unsigned U_W = COORD_W - 1;

  logic               ov_q;
  logic [IDX_W-1:0]   index_q;
  logic [COLOR_W-1:0] color_q;
  logic               last_q;

  logic [U_W-1:0]     x_u, y_u;
  logic               on_screen;
  logic [PROD_W-1:0]  prod;

  assign x_u = pix_i.x[U_W-1:0];
  assign y_u = pix_i.y[U_W-1:0];

  assign on_screen = !pix_i.x[COORD_W-1] && (x_u < U_W'(SCREEN_WIDTH))
                  && !pix_i.y[COORD_W-1] && (y_u < U_W'(SCREEN_HEIGHT));

  assign prod = PROD_W'(y_u) * PROD_W'(SCREEN_WIDTH) + PROD_W'(x_u);

  assign pix_ready_o = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (pix_ready_o) begin
      ov_q <= pix_valid_i && on_screen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      index_q <= prod[IDX_W-1:0];
      color_q <= pix_i.color;
      last_q  <= pix_i.last;
    end
  end

  assign out_valid_o = ov_q;
  assign index_o     = index_q;
  assign color_o     = color_q;
  assign last_o      = last_q;

  `BPFB_ASSERT(a_index_on_screen, ov_q |-> index_q < IDX_W'(SCREEN_PIXELS), "index off screen")
  `BPFB_ASSERT(a_out_holds, ov_q && !out_ready_i |=> ov_q && $stable(index_q), "result lost")
  `BPFB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !ov_q, "output valid in reset")

endmodule

// File: design/bmp_pixels_to_framebuffer.sv
// BMP pixel array to ARGB8888 framebuffer writer.
// s_axis carries one byte of the BMP pixel array per item, in file order
// (rows bottom-up, B G R [A] per pixel, rows padded to four bytes in 24-bit
// mode). m_axis carries one item per on-screen pixel: the framebuffer word
// index (row * 800 + column) and the ARGB8888 color; tlast marks the image's
// final pixel. Off-screen pixels, pad bytes and bytes after the last row
// produce nothing.
// The cfg channel writes origin_x, origin_y, image_width, image_height and
// has_alpha (indexes 0..4); it is always ready and must only be used while
// the block is idle. Unmapped indexes are ignored.
// Throughput: one byte per cycle while m_axis is not stalled. A pixel's color
// reaches m_axis through the unpack register, then the placement register with
// the row * 800 multiply.
// Reset clears the byte/pixel/row counters, restores the register defaults
// (800 x 480, origin 0, 24-bit) and empties both stages. When m_axis stalls,
// the placement stage holds its item, the unpack stage fills, and s_axis
// tready drops after one more pixel is buffered.
module bmp_pixels_to_framebuffer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel byte stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel_byte
  // framebuffer writes
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [18:0] write_index, [50:19] pixel_color, [55:51] zero
  output logic [bpfb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast,   // last_pixel
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bpfb_pkg::CFG_W-1:0]        cfg_data_i
);
  import bpfb_pkg::*;

  cfg_t               cfg;
  logic               pix_valid, pix_ready;
  pix_t               pix;
  logic [IDX_W-1:0]   wr_index;
  logic [COLOR_W-1:0] wr_color;

  assign cfg_ready_o = 1'b1;

  bpfb_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i && cfg_ready_o),
    .wr_idx_i (cfg_index_i),
    .wr_data_i(cfg_data_i),
    .cfg_o    (cfg)
  );

  // byte gathering, row padding and position counters
  bpfb_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .byte_valid_i(s_axis_tvalid),
    .byte_ready_o(s_axis_tready),
    .byte_i      (s_axis_tdata),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix)
  );

  // clipping and framebuffer address
  bpfb_place u_place (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_valid_i(pix_valid),
    .pix_ready_o(pix_ready),
    .pix_i      (pix),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .index_o    (wr_index),
    .color_o    (wr_color),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-IDX_W-COLOR_W){1'b0}}, wr_color, wr_index};

endmodule

// File: tb/bpfb_fb_checker.sv
`timescale 1ns / 1ps

module bpfb_fb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  input  logic                             s_ready_i,
  input  logic [7:0]                       s_data_i,
  input  logic                             m_valid_i,
  input  logic                             m_ready_i,
  input  logic [bpfb_pkg::OUT_TDATA_W-1:0] m_data_i,
  input  logic                             m_last_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [bpfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bpfb_pkg::CFG_W-1:0]       cfg_data_i,
  output int                               fail_count_o,
  output int                               writes_pending_o,
  output logic [bpfb_pkg::CFG_W-1:0]       rows_done_o
);
  import bpfb_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   word_index;
    logic [COLOR_W-1:0] color;
    logic               is_last;
  } fb_write_t;

  cfg_t             regs;
  logic [1:0]       byte_pos;
  logic [23:0]      gathered;
  logic [CFG_W-1:0] pix_col;
  logic [CFG_W-1:0] pix_row;
  logic [1:0]       pad_left;
  logic             image_done;
  fb_write_t        fb_writes_q[$];
  int               mismatches = 0;

  // Advances the pixel unpacker by one byte and queues the framebuffer
  // write it produces, if any.
  task automatic place_pixel_byte(input logic [7:0] b);
    logic [7:0]       alpha;
    logic [CFG_W-1:0] col;
    logic [CFG_W-1:0] row;
    bit               row_end;
    bit               is_last;
    int               x;
    int               y;
    fb_write_t        w;
    alpha = '0;
    if (image_done) return;
    if (pad_left != 0) begin
      pad_left--;
      return;
    end
    case (byte_pos)
      2'd0: begin
        gathered[7:0] = b;
        byte_pos = 2'd1;
        return;
      end
      2'd1: begin
        gathered[15:8] = b;
        byte_pos = 2'd2;
        return;
      end
      2'd2: begin
        gathered[23:16] = b;
        if (regs.has_alpha) begin
          byte_pos = 2'd3;
          return;
        end
      end
      default: alpha = b;
    endcase
    byte_pos = '0;

    col = pix_col;
    row = pix_row;
    row_end = int'(col) + 1 >= int'(regs.image_width);
    is_last = row_end && (int'(row) + 1 >= int'(regs.image_height));
    if (row_end) begin
      pix_col = '0;
      pix_row = row + 1'b1;
      if (is_last) image_done = 1'b1;
      else if (!regs.has_alpha) pad_left = 2'(-3 * int'(regs.image_width));
    end else begin
      pix_col = col + 1'b1;
    end

    // bottom-up rows: file row 0 is the image's lowest screen row
    x = int'($signed(regs.origin_x)) + int'(col);
    y = int'($signed(regs.origin_y)) + int'(regs.image_height) - int'(row) - 1;
    if (x < 0 || x >= int'(SCREEN_WIDTH) || y < 0 || y >= int'(SCREEN_HEIGHT)) return;
    w.word_index = IDX_W'(y * int'(SCREEN_WIDTH) + x);
    w.color      = {alpha, gathered};
    w.is_last    = is_last;
    fb_writes_q.push_back(w);
  endtask

  task automatic check_fb_write();
    fb_write_t          want;
    logic [IDX_W-1:0]   got_index;
    logic [COLOR_W-1:0] got_color;
    got_index = m_data_i[IDX_W-1:0];
    got_color = m_data_i[IDX_W +: COLOR_W];
    if (fb_writes_q.size() == 0) begin
      $error("unexpected framebuffer write: write_index %0d, pixel_color %h",
             got_index, got_color);
      mismatches++;
      return;
    end
    want = fb_writes_q.pop_front();
    if (got_index !== want.word_index) begin
      $error("write_index: expected %0d, got %0d", want.word_index, got_index);
      mismatches++;
    end
    if (got_color !== want.color) begin
      $error("pixel_color: expected %h, got %h", want.color, got_color);
      mismatches++;
    end
    if (m_last_i !== want.is_last) begin
      $error("last_pixel: expected %0b, got %0b", want.is_last, m_last_i);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs              = '0;
      regs.image_width  = WIDTH_RST;
      regs.image_height = HEIGHT_RST;
      byte_pos          = '0;
      gathered          = '0;
      pix_col           = '0;
      pix_row           = '0;
      pad_left          = '0;
      image_done        = 1'b0;
      fb_writes_q.delete();
      writes_pending_o <= 0;
      rows_done_o      <= '0;
    end else begin
      if (m_valid_i && m_ready_i) check_fb_write();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:     regs.origin_x = cfg_data_i;
          REG_ORIGIN_Y:     regs.origin_y = cfg_data_i;
          REG_IMAGE_WIDTH:  regs.image_width = cfg_data_i;
          REG_IMAGE_HEIGHT: regs.image_height = cfg_data_i;
          REG_HAS_ALPHA:    regs.has_alpha = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) place_pixel_byte(s_data_i);
      writes_pending_o <= fb_writes_q.size();
      rows_done_o      <= pix_row;
      fail_count_o     <= mismatches;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bpfb_pkg::*;

  localparam int ITEM_TARGET    = 1800;
  localparam int SETTLE_CYCLES  = 8;     // two-stage pipe plus margin
  localparam int HOLD_CYCLES    = 300;   // long output stall, fills both stages
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int ROW_MARGIN     = 60;    // more rows than one phase can finish
  localparam int ORIGIN_MIN     = -2048;
  localparam int ORIGIN_MAX     = 2047;
  localparam int CFG_MAX        = (1 << CFG_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_HAS_ALPHA + 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;   // [7:0] pixel_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [18:0] write_index, [50:19] pixel_color
  logic                   m_axis_tlast;         // last_pixel
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data  = '0;

  int               fail_count;
  int               writes_pending;
  logic [CFG_W-1:0] rows_done;

  int sent_count   = 0;
  int tx_gap_max   = 0;
  int rx_gap_max   = 0;
  bit hold_req     = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  bmp_pixels_to_framebuffer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bpfb_fb_checker fb_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_valid_i        (s_axis_tvalid),
    .s_ready_i        (s_axis_tready),
    .s_data_i         (s_axis_tdata),
    .m_valid_i        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .m_data_i         (m_axis_tdata),
    .m_last_i         (m_axis_tlast),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .writes_pending_o (writes_pending),
    .rows_done_o      (rows_done)
  );

  // Watchdog: any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bmp_pixels_to_framebuffer regression: fail");
      $finish;
    end
  end

  // Framebuffer side: random stall before each item, plus one long hold-off
  // on request so the block backs up into its byte input.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = $urandom_range(0, rx_gap_max);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // One byte item; valid stays high across back-to-back items.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All five registers, now and then a write to an unmapped index too.
  task automatic configure(input int ox, input int oy, input int img_w, input int img_h,
                           input bit alpha);
    reg_write(REG_ORIGIN_X, CFG_W'(ox));
    reg_write(REG_ORIGIN_Y, CFG_W'(oy));
    reg_write(REG_IMAGE_WIDTH, CFG_W'(img_w));
    reg_write(REG_IMAGE_HEIGHT, CFG_W'(img_h));
    reg_write(REG_HAS_ALPHA, CFG_W'(alpha));
    if ($urandom_range(0, 7) == 0)
      reg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, drain every expected write, then give off-screen pixels
  // still in the pipe time to fall out before touching registers.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 14;
    endcase
  endfunction

  // One random geometry and a run of random bytes. Height is always kept
  // ahead of the row count so the image does not end mid-run; origin_y is
  // picked so the rows of this run mostly land on screen, some just off its edges.
  task automatic random_phase(input bit squeeze);
    int rows;
    int img_w;
    int img_h;
    int ox;
    int oy;
    int n;
    bit alpha;
    settle();
    rows  = int'(rows_done);
    alpha = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       ox = ORIGIN_MIN;
      1:       ox = ORIGIN_MAX;
      2:       ox = int'(SCREEN_WIDTH) - int'($urandom_range(1, 8));
      3:       ox = -int'($urandom_range(1, 8));
      default: ox = $urandom_range(0, SCREEN_WIDTH - 20);
    endcase
    case ($urandom_range(0, 9))
      0:       img_w = 0;
      1:       img_w = CFG_MAX;
      2:       img_w = $urandom_range(9, 60);
      default: img_w = $urandom_range(1, 8);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      // tall image: everything off screen, any origin_y
      img_h = CFG_MAX;
      oy    = int'($urandom_range(0, CFG_MAX)) + ORIGIN_MIN;
    end else begin
      img_h = rows + ROW_MARGIN + int'($urandom_range(0, 200));
      oy    = int'($urandom_range(0, SCREEN_HEIGHT + 40)) - 20 - (img_h - 1 - rows);
    end
    n          = $urandom_range(20, 120);
    tx_gap_max = pick_gap_max();
    rx_gap_max = pick_gap_max();
    if (squeeze) begin
      // on-screen, back-to-back bytes while the output side holds off
      ox         = 100;
      img_w      = 8;
      alpha      = 1'b0;
      img_h      = rows + ROW_MARGIN;
      oy         = int'(SCREEN_HEIGHT) / 2 - (img_h - 1 - rows);
      n          = 200;
      tx_gap_max = 0;
      hold_req   = 1'b1;
    end
    configure(ox, oy, img_w, img_h, alpha);
    repeat (n) send_byte(8'($urandom));
  endtask

  initial begin
    int phase_no;
    // falling edge at time zero so the async reset takes hold before any clock
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    tx_gap_max = 0;
    rx_gap_max = 3;
    // Reset geometry, 24-bit: first pixels go to the bottom-left corner.
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
    send_byte(8'hA5); send_byte(8'h0F); send_byte(8'hF0);
    settle();

    // One-pixel rows in 24-bit mode: one pad byte after each pixel.
    configure(0, 0, 1, 200, 1'b0);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'hCC);
    send_byte(8'h44); send_byte(8'h55); send_byte(8'h66); send_byte(8'h33);
    settle();

    // 32-bit pixel on the right screen edge, no padding.
    configure(int'(SCREEN_WIDTH) - 1, 0, 1, 200, 1'b1);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'hFE);
    settle();

    // Zero width, far off screen: one-pixel rows, nothing written. Then stop
    // after the red byte of a 32-bit pixel and drop to 24-bit mode: the next
    // byte must still be taken as alpha.
    configure(ORIGIN_MIN, ORIGIN_MAX, 0, CFG_MAX, 1'b1);
    send_byte(8'h80); send_byte(8'h7F); send_byte(8'hC3); send_byte(8'h3C);
    send_byte(8'hDE); send_byte(8'hAD); send_byte(8'hBE);
    settle();
    configure(5, 0, CFG_MAX, 200, 1'b0);
    send_byte(8'hEF);

    phase_no = 0;
    while (sent_count < ITEM_TARGET) begin
      random_phase(phase_no == 4);
      phase_no++;
    end

    // Close the image three rows on: its final pixel lands on screen row 0
    // and carries tlast. Trailing bytes must be ignored.
    settle();
    tx_gap_max = 3;
    configure(10, 0, 2, int'(rows_done) + 3, 1'b0);
    repeat (40) send_byte(8'($urandom));
    settle();

    if (fail_count == 0) begin
      $display("bmp_pixels_to_framebuffer regression: pass");
    end else begin
      $display("bmp_pixels_to_framebuffer regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/bpfb_pkg.sv
design/bpfb_cfg.sv
design/bpfb_unpack.sv
design/bpfb_place.sv
design/bmp_pixels_to_framebuffer.sv
tb/bpfb_fb_checker.sv
tb/tb.sv
